// File: sv/lru_kv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lru_kv_pkg;

  localparam int ENTRIES     = 16;
  localparam int LENGTH_BITS = 16;
  localparam int STAMP_BITS  = 32;

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LEN_KEEP = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] key;
    logic [63:0] value_in;
    logic [15:0] length_in;
  } in_req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic [15:0] length_out;
  } out_res_t;

  // Search token that walks the cell row, one cell a cycle.
  typedef struct packed {
    logic                  valid;
    logic                  op;
    logic [63:0]           key;
    logic [63:0]           value;
    logic [15:0]           length;
    logic [IDX_BITS-1:0]   pos;
    logic                  sel;
    logic [IDX_BITS-1:0]   sel_idx;
    logic                  have_best;
    logic [STAMP_BITS-1:0] best_stamp;
    logic [IDX_BITS-1:0]   best_idx;
  } probe_t;

  // Write-back data broadcast to the row; at most one cell is enabled.
  typedef struct packed {
    logic                  write_all;
    logic [63:0]           key;
    logic [63:0]           value;
    logic [15:0]           length;
    logic [STAMP_BITS-1:0] stamp;
  } wb_t;

endpackage

// File: sv/lru_key_value_cache.sv
// LRU key/value cache: top level with the cell row and write-back control.
//
// Usage: a request on in_data (valid/stall) is either a lookup (operation 0)
// or a record (operation 1). A lookup gives one result on out_data: hit with
// the stored value and length, or hit 0 with zero fields on a miss. A record
// gives no result; it fills the lowest empty entry, else the entry with the
// oldest stamp (lowest index on ties), and stamps it.
// The request walks a row of ENTRIES cells, one cell a cycle, then a single
// write-back updates the chosen entry and the stamp counter.
// One request is taken at a time: it passes the launch register, the walk
// along the cell row, the write-back and, for a lookup, the pending register.
// in_stall is high while a request is in flight or its result is pending.
// When out_stall holds a result, a later lookup result waits in a pending
// register and the input stays stalled until it moves to the output.
// Reset (rst_n low, synchronous) empties the store, clears all stamps and
// the stamp counter, and drops any request or result in flight.
module lru_key_value_cache (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lru_kv_pkg::in_req_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lru_kv_pkg::out_res_t out_data
);
  import lru_kv_pkg::*;

  logic                  busy_r;
  logic                  head_valid_r;
  probe_t                head_r;
  probe_t                head_probe;
  logic                  pend_valid_r;
  out_res_t              pend_r;
  logic                  out_valid_r;
  out_res_t              out_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [STAMP_BITS-1:0] stamp_inc;

  probe_t                chain [ENTRIES+1];
  probe_t                pe;
  logic [ENTRIES:0]      live;
  logic [ENTRIES-1:0]    wb_en;
  logic                  wb_sel;
  logic [IDX_BITS-1:0]   target;
  wb_t                   wb;
  logic                  accept;
  logic                  out_free;

  assign in_stall  = busy_r;
  assign accept    = in_valid && !busy_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Launch a new request into the row
  always_ff @(posedge clk) begin
    if (accept) begin
      head_r.valid      <= 1'b1;
      head_r.op         <= in_data.operation;
      head_r.key        <= in_data.key;
      head_r.value      <= (in_data.operation == OP_RECORD) ? in_data.value_in : '0;
      head_r.length     <= (in_data.operation == OP_RECORD) ? in_data.length_in : '0;
      head_r.pos        <= '0;
      head_r.sel        <= 1'b0;
      head_r.sel_idx    <= '0;
      head_r.have_best  <= 1'b0;
      head_r.best_stamp <= '0;
      head_r.best_idx   <= '0;
    end
  end

  always_comb begin
    head_probe       = head_r;
    head_probe.valid = head_valid_r;
  end

  assign chain[0] = head_probe;

  // Row of entry cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign wb_en[i] = wb_sel && (target == IDX_BITS'(i));
    lru_kv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1]),
      .wb_en     (wb_en[i]),
      .wb        (wb)
    );
  end

  for (genvar j = 0; j <= ENTRIES; j++) begin : g_live
    assign live[j] = chain[j].valid;
  end

  assign pe = chain[ENTRIES];

  // Pick the entry to write back when the token leaves the row
  always_comb begin
    stamp_inc    = (stamp_r != STAMP_MAX) ? stamp_r + 1'b1 : stamp_r;
    wb_sel       = pe.valid && (pe.op == OP_RECORD || pe.sel);
    target       = (pe.op == OP_RECORD && !pe.sel) ? pe.best_idx : pe.sel_idx;
    wb.write_all = (pe.op == OP_RECORD);
    wb.key       = pe.key;
    wb.value     = pe.value;
    wb.length    = pe.length;
    wb.stamp     = stamp_inc;
  end

  // Control: busy, stamp counter, pending and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      head_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      stamp_r      <= '0;
    end else begin
      head_valid_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (wb_sel) begin
        stamp_r <= stamp_inc;
      end
      if (pe.valid && pe.op == OP_RECORD) begin
        busy_r <= 1'b0;
      end
      if (pe.valid && pe.op == OP_LOOKUP) begin
        pend_valid_r <= 1'b1;
      end
      if (pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
        busy_r       <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pe.valid && pe.op == OP_LOOKUP) begin
      pend_r.hit        <= pe.sel;
      pend_r.value_out  <= pe.value;
      pend_r.length_out <= pe.length;
    end
    if (pend_valid_r && out_free) begin
      out_r <= pend_r;
    end
  end

`ifndef SYNTH
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(live))
    else $error("more than one request in the cell row");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wb_en))
    else $error("more than one entry written back");

  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (|live) |-> busy_r)
    else $error("request in the row while not busy");

  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (busy_r && !(|live)))
    else $error("pending result without its request");
`endif

endmodule

// File: sv/lru_kv_cell.sv
// One cache entry with its stage of the search token row.
module lru_kv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lru_kv_pkg::probe_t probe_in,
  output lru_kv_pkg::probe_t probe_out,
  input  logic               wb_en,
  input  lru_kv_pkg::wb_t    wb
);
  import lru_kv_pkg::*;

  logic                  valid_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [63:0]           key_r;
  logic [63:0]           value_r;
  logic [LEN_KEEP-1:0]   len_r;
  logic                  probe_valid_r;
  probe_t                probe_r;
  probe_t                probe_nxt;

  // Match or rank this entry against the passing request
  always_comb begin
    probe_nxt     = probe_in;
    probe_nxt.pos = probe_in.pos + 1'b1;
    if (probe_in.valid && !probe_in.sel) begin
      if (probe_in.op == OP_LOOKUP) begin
        if (valid_r && key_r == probe_in.key) begin
          probe_nxt.sel     = 1'b1;
          probe_nxt.sel_idx = probe_in.pos;
          probe_nxt.value   = value_r;
          probe_nxt.length  = 16'(len_r);
        end
      end else begin
        if (!valid_r) begin
          probe_nxt.sel     = 1'b1;
          probe_nxt.sel_idx = probe_in.pos;
        end else if (!probe_in.have_best || stamp_r < probe_in.best_stamp) begin
          probe_nxt.have_best  = 1'b1;
          probe_nxt.best_stamp = stamp_r;
          probe_nxt.best_idx   = probe_in.pos;
        end
      end
    end
  end

  // Hold entry control state and advance the token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      stamp_r       <= '0;
      probe_valid_r <= 1'b0;
    end else begin
      probe_valid_r <= probe_in.valid;
      if (wb_en) begin
        valid_r <= 1'b1;
        stamp_r <= wb.stamp;
      end
    end
  end

  // Entry payload and token payload
  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    if (wb_en && wb.write_all) begin
      key_r   <= wb.key;
      value_r <= wb.value;
      len_r   <= wb.length[LEN_KEEP-1:0];
    end
  end

  always_comb begin
    probe_out       = probe_r;
    probe_out.valid = probe_valid_r;
  end

endmodule
